/* hw/rtl/dlpg_pkg.sv */
package dlpg_pkg;

  // operation carried in s_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // controller states
  typedef enum logic {
    ST_READY,
    ST_DIVIDE
  } state_t;

endpackage

/* hw/rtl/dda_line_point_generator.sv */
// DDA line point generator. A load transaction (s_tuser = 0) takes two integer endpoints and
// prepares a line of max(|dx|,|dy|)+1 points; each step transaction (s_tuser = 1) then
// returns one point, rounded half away from zero, and the final point of the line comes
// with m_tlast set. A step while no line is in progress returns nothing. Step transactions
// are taken one per cycle as long as the output is drained. After a load is accepted, the
// bit-serial restoring divider forms both per-step increments, one quotient bit per cycle
// for x and y together; s_tready stays low while it runs. Equal endpoints skip the divider.
// A load replaces any line in progress.
module dda_line_point_generator #(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  // input transactions
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // start_x, start_y, end_x, end_y from the lowest bit up, zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  // opcode
  input  logic                                  s_tuser,
  // result transactions
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // point_x, point_y from the lowest bit up, zero padded
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
  // last_point
  output logic                                  m_tlast
);

  localparam int AccW  = COORD_BITS + FRAC_BITS + 1;
  localparam int IncW  = FRAC_BITS + 2;
  localparam int QW    = FRAC_BITS + 1;
  localparam int RemW  = COORD_BITS + 1;
  localparam int DiffW = COORD_BITS + 1;
  localparam int PtsW  = COORD_BITS + 1;
  localparam int CntW  = $clog2(FRAC_BITS + 1);
  localparam int OutW  = ((2*COORD_BITS+7)/8)*8;
  localparam logic [AccW-1:0] HalfC = AccW'(1) << (FRAC_BITS - 1);

  dlpg_pkg::state_t state, state_next;

  logic signed [AccW-1:0] acc_x, acc_y;
  logic signed [IncW-1:0] inc_x, inc_y;
  logic [PtsW-1:0]        points_left;
  logic                   line_active;

  // divider registers
  logic [RemW-1:0]       rem_x, rem_y;
  logic [QW-1:0]         quo_x, quo_y;
  logic [COORD_BITS-1:0] steps;
  logic                  neg_x, neg_y;
  logic [CntW-1:0]       cnt;

  logic [COORD_BITS-1:0] pt_x, pt_y;

  // handshake
  logic in_fire, load_fire, step_fire, div_done;

  assign s_tready  = (state == dlpg_pkg::ST_READY) && (!m_tvalid || m_tready);
  assign in_fire   = s_tvalid && s_tready;
  assign load_fire = in_fire && (s_tuser == dlpg_pkg::OP_LOAD);
  assign step_fire = in_fire && (s_tuser == dlpg_pkg::OP_STEP) && line_active;

  // endpoint differences and step count
  logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
  logic signed [DiffW-1:0]      dx, dy;
  logic [DiffW-1:0]             adx, ady;
  logic [COORD_BITS-1:0]        steps_in;

  always_comb begin
    sx = s_tdata[0 +: COORD_BITS];
    sy = s_tdata[COORD_BITS +: COORD_BITS];
    ex = s_tdata[2*COORD_BITS +: COORD_BITS];
    ey = s_tdata[3*COORD_BITS +: COORD_BITS];
    dx = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
    dy = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
    adx = dx[DiffW-1] ? -dx : dx;
    ady = dy[DiffW-1] ? -dy : dy;
    steps_in = (adx >= ady) ? adx[COORD_BITS-1:0] : ady[COORD_BITS-1:0];
  end

  // one restoring division step for each axis
  logic [RemW-1:0] steps_ext, trial_x, trial_y, keep_x, keep_y;
  logic            bit_x, bit_y;
  logic [QW-1:0]   qf_x, qf_y;

  always_comb begin
    steps_ext = {1'b0, steps};
    trial_x   = rem_x - steps_ext;
    trial_y   = rem_y - steps_ext;
    bit_x     = (rem_x >= steps_ext);
    bit_y     = (rem_y >= steps_ext);
    keep_x    = bit_x ? trial_x : rem_x;
    keep_y    = bit_y ? trial_y : rem_y;
    qf_x      = {quo_x[QW-2:0], bit_x};
    qf_y      = {quo_y[QW-2:0], bit_y};
  end

  // point rounding, half away from zero
  logic [AccW-1:0] rnd_x, rnd_y;

  always_comb begin
    rnd_x = acc_x + HalfC - {{(AccW-1){1'b0}}, acc_x[AccW-1]};
    rnd_y = acc_y + HalfC - {{(AccW-1){1'b0}}, acc_y[AccW-1]};
    pt_x  = rnd_x[FRAC_BITS +: COORD_BITS];
    pt_y  = rnd_y[FRAC_BITS +: COORD_BITS];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlpg_pkg::ST_READY;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    div_done   = 1'b0;
    unique case (state)
      dlpg_pkg::ST_READY: begin
        if (load_fire && (steps_in != '0)) begin
          state_next = dlpg_pkg::ST_DIVIDE;
        end
      end
      dlpg_pkg::ST_DIVIDE: begin
        if (cnt == '0) begin
          div_done   = 1'b1;
          state_next = dlpg_pkg::ST_READY;
        end
      end
      default: state_next = dlpg_pkg::ST_READY;
    endcase
  end

  // line state, divider and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x       <= '0;
      acc_y       <= '0;
      inc_x       <= '0;
      inc_y       <= '0;
      points_left <= '0;
      line_active <= 1'b0;
      m_tvalid    <= 1'b0;
      cnt         <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (load_fire) begin
        acc_x       <= {sx[COORD_BITS-1], sx, {FRAC_BITS{1'b0}}};
        acc_y       <= {sy[COORD_BITS-1], sy, {FRAC_BITS{1'b0}}};
        inc_x       <= '0;
        inc_y       <= '0;
        points_left <= {1'b0, steps_in} + PtsW'(1);
        line_active <= 1'b1;
        steps       <= steps_in;
        neg_x       <= dx[DiffW-1];
        neg_y       <= dy[DiffW-1];
        rem_x       <= {1'b0, adx[COORD_BITS-1:0]};
        rem_y       <= {1'b0, ady[COORD_BITS-1:0]};
        quo_x       <= '0;
        quo_y       <= '0;
        cnt         <= CntW'(FRAC_BITS);
      end else if (step_fire) begin
        m_tvalid    <= 1'b1;
        m_tdata     <= {{(OutW-2*COORD_BITS){1'b0}}, pt_y, pt_x};
        m_tlast     <= (points_left == PtsW'(1));
        points_left <= points_left - PtsW'(1);
        if (points_left == PtsW'(1)) begin
          line_active <= 1'b0;
        end
        acc_x <= acc_x + {{(AccW-IncW){inc_x[IncW-1]}}, inc_x};
        acc_y <= acc_y + {{(AccW-IncW){inc_y[IncW-1]}}, inc_y};
      end

      // one quotient bit per cycle
      if (state == dlpg_pkg::ST_DIVIDE) begin
        rem_x <= {keep_x[RemW-2:0], 1'b0};
        rem_y <= {keep_y[RemW-2:0], 1'b0};
        quo_x <= qf_x;
        quo_y <= qf_y;
        cnt   <= cnt - CntW'(1);
        if (div_done) begin
          inc_x <= neg_x ? -{1'b0, qf_x} : {1'b0, qf_x};
          inc_y <= neg_y ? -{1'b0, qf_y} : {1'b0, qf_y};
        end
      end
    end
  end

endmodule
